// ----- rtl/bqeq_pkg.sv -----
// ----------------------------------------------------------------------------
// bqeq_pkg
// shared widths, register indexes and reset values of the boost/cut equalizer
// ----------------------------------------------------------------------------
package bqeq_pkg;

    // fixed port and coefficient formats
    localparam int COEF_BITS   = 32;
    localparam int PORT_BITS   = 32;
    localparam int CFG_IDX_BITS = 3;

    // defaults of the top level parameters
    localparam int SAMPLE_BITS_DEF      = 32;
    localparam int COEF_FRAC_BITS_DEF   = 30;
    localparam int STATE_GUARD_BITS_DEF = 8;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_DRY_GAIN = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_B0  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_B1  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_B2  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_A1  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_COEF_A2  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_BYPASS   = 3'd6;

    // 10^(0.88/20) in q2.30
    localparam logic signed [COEF_BITS-1:0] DRY_GAIN_RESET = 32'sd1188224177;

endpackage

// ----- rtl/biquad_boost_cut_eq_unit.sv -----
// ----------------------------------------------------------------------------
// biquad_boost_cut_eq_unit
// boost/cut equalizer: gain-scaled sample plus one df1 biquad band-pass,
// saturated, computed with one shared multiplier under a small sequencer
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_sample_in
//  out     | output    | o_out_valid / i_out_stall  | o_sample_out, o_clipped
//  cfg     | input     | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
//  an equalized sample runs through the whole sequence before the next input
//  transaction: the single 32 x (SAMPLE_BITS+STATE_GUARD_BITS) multiplier
//  issues six products (gain, then five taps), each registered before use,
//  followed by rounding, state update and output saturation. a bypassed
//  sample goes from the idle step straight to the hand-off step.
//  input is taken only when the sequencer is idle; a finished result waits in
//  the output register and the next sample is taken meanwhile, the sequencer
//  holds in its last step only while that register is still full and stalled.
//  reset (synchronous, active low) clears the filter history, restores the
//  default gain and zeroes the coefficients and the bypass bit.
//
module biquad_boost_cut_eq_unit
    import bqeq_pkg::*;
#(
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS   = COEF_FRAC_BITS_DEF,
    parameter int STATE_GUARD_BITS = STATE_GUARD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [COEF_BITS-1:0]          i_cfg_data,
    // sample in
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [PORT_BITS-1:0]   i_sample_in,
    // sample out
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [PORT_BITS-1:0]   o_sample_out,
    output logic                          o_clipped
);

    // widths: past inputs, past outputs, one product, the accumulator
    localparam int IW = SAMPLE_BITS + 2;
    localparam int OW = SAMPLE_BITS + STATE_GUARD_BITS;
    localparam int PW = COEF_BITS + OW;
    localparam int AW = PW + 3;
    localparam int SW = OW + 1;

    localparam logic signed [PW-1:0] PROD_ROUND = PW'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [AW-1:0] ACC_ROUND  = AW'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [OW-1:0] Y_MAX = {1'b0, {(OW-1){1'b1}}};
    localparam logic signed [OW-1:0] Y_MIN = {1'b1, {(OW-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [2:0] LAST_TAP = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAIN,    // x * dry_gain into the product register
        ST_DRY,     // round d, preload the accumulator with the rounding bias
        ST_MAC,     // one tap product issued per cycle, previous one accumulated
        ST_DRAIN,   // accumulate the last tap product
        ST_Y,       // round and saturate y, shift the history
        ST_SUM,     // d + y saturated to the sample range
        ST_DONE     // hand the result to the output register
    } t_state;

    // configuration registers
    logic signed [COEF_BITS-1:0] r_dry_gain;
    logic signed [COEF_BITS-1:0] r_coef_b0, r_coef_b1, r_coef_b2;
    logic signed [COEF_BITS-1:0] r_coef_a1, r_coef_a2;
    logic                        r_bypass;

    // sequencer and datapath registers
    t_state                      r_state;
    logic [2:0]                  r_tap;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [PW-1:0]        r_prod;
    logic signed [AW-1:0]        r_acc;
    logic signed [IW-1:0]        r_d;
    logic signed [OW-1:0]        r_y;
    logic signed [IW-1:0]        r_prev_in_1, r_prev_in_2;
    logic signed [OW-1:0]        r_prev_out_1, r_prev_out_2;
    logic signed [PORT_BITS-1:0] r_result;
    logic                        r_result_clip;
    logic                        r_out_valid;
    logic signed [PORT_BITS-1:0] r_sample_out;
    logic                        r_clipped;

    // shared multiplier operands
    logic signed [COEF_BITS-1:0] w_mul_a;
    logic signed [OW-1:0]        w_mul_b;
    logic signed [PW-1:0]        w_prod;

    logic signed [PW-1:0]        w_d_full;
    logic signed [AW-1:0]        w_acc_sh;
    logic [AW-OW:0]              w_acc_top;
    logic                        w_y_ovf;
    logic signed [OW-1:0]        w_y;
    logic signed [SW-1:0]        w_sum;
    logic [SW-SAMPLE_BITS:0]     w_sum_top;
    logic                        w_sum_ovf;
    logic signed [SAMPLE_BITS-1:0] w_sum_sat;
    logic                        w_in_take;
    logic                        w_out_free;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dry_gain <= DRY_GAIN_RESET;
            r_coef_b0  <= '0;
            r_coef_b1  <= '0;
            r_coef_b2  <= '0;
            r_coef_a1  <= '0;
            r_coef_a2  <= '0;
            r_bypass   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DRY_GAIN: r_dry_gain <= i_cfg_data;
                REG_COEF_B0:  r_coef_b0  <= i_cfg_data;
                REG_COEF_B1:  r_coef_b1  <= i_cfg_data;
                REG_COEF_B2:  r_coef_b2  <= i_cfg_data;
                REG_COEF_A1:  r_coef_a1  <= i_cfg_data;
                REG_COEF_A2:  r_coef_a2  <= i_cfg_data;
                REG_BYPASS:   r_bypass   <= i_cfg_data[0];
                default:      ;  // unused index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------ operand select
    always_comb begin
        w_mul_a = r_dry_gain;
        w_mul_b = OW'(r_x);
        if (r_state == ST_MAC) begin
            case (r_tap)
                3'd0: begin
                    w_mul_a = r_coef_b0;
                    w_mul_b = OW'(r_d);
                end
                3'd1: begin
                    w_mul_a = r_coef_b1;
                    w_mul_b = OW'(r_prev_in_1);
                end
                3'd2: begin
                    w_mul_a = r_coef_b2;
                    w_mul_b = OW'(r_prev_in_2);
                end
                3'd3: begin
                    w_mul_a = r_coef_a1;
                    w_mul_b = r_prev_out_1;
                end
                default: begin
                    w_mul_a = r_coef_a2;
                    w_mul_b = r_prev_out_2;
                end
            endcase
        end
    end

    // the one multiplier of the block
    assign w_prod = w_mul_a * w_mul_b;

    // d: round half up then floor shift, always fits IW bits
    assign w_d_full = (r_prod + PROD_ROUND) >>> COEF_FRAC_BITS;

    // y: accumulator already holds the rounding bias
    assign w_acc_sh  = r_acc >>> COEF_FRAC_BITS;
    assign w_acc_top = w_acc_sh[AW-1:OW-1];
    assign w_y_ovf   = !((&w_acc_top) || !(|w_acc_top));
    assign w_y       = w_y_ovf ? (w_acc_sh[AW-1] ? Y_MIN : Y_MAX) : w_acc_sh[OW-1:0];

    // dry plus wet, saturated to the sample range
    assign w_sum     = SW'(r_d) + SW'(r_y);
    assign w_sum_top = w_sum[SW-1:SAMPLE_BITS-1];
    assign w_sum_ovf = !((&w_sum_top) || !(|w_sum_top));
    assign w_sum_sat = w_sum_ovf ? (w_sum[SW-1] ? S_MIN : S_MAX)
                                 : w_sum[SAMPLE_BITS-1:0];

    assign w_in_take  = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // ------------------------------------------------------------ sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_tap        <= '0;
            r_out_valid  <= 1'b0;
            r_prev_in_1  <= '0;
            r_prev_in_2  <= '0;
            r_prev_out_1 <= '0;
            r_prev_out_2 <= '0;
        end else begin
            // drained output empties unless the hand-off step refills it
            if (r_out_valid && !i_out_stall && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_take) begin
                        r_x <= i_sample_in[SAMPLE_BITS-1:0];
                        if (r_bypass) begin
                            // untouched sample, history holds
                            r_result      <= i_sample_in;
                            r_result_clip <= 1'b0;
                            r_state       <= ST_DONE;
                        end else begin
                            r_state <= ST_GAIN;
                        end
                    end
                end
                ST_GAIN: begin
                    r_prod  <= w_prod;
                    r_state <= ST_DRY;
                end
                ST_DRY: begin
                    r_d     <= w_d_full[IW-1:0];
                    r_acc   <= ACC_ROUND;
                    r_tap   <= '0;
                    r_state <= ST_MAC;
                end
                ST_MAC: begin
                    r_prod <= w_prod;
                    if (r_tap != 3'd0) begin
                        r_acc <= r_acc + AW'(r_prod);
                    end
                    if (r_tap == LAST_TAP) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_tap <= r_tap + 3'd1;
                    end
                end
                ST_DRAIN: begin
                    r_acc   <= r_acc + AW'(r_prod);
                    r_state <= ST_Y;
                end
                ST_Y: begin
                    r_y          <= w_y;
                    r_prev_in_2  <= r_prev_in_1;
                    r_prev_in_1  <= r_d;
                    r_prev_out_2 <= r_prev_out_1;
                    r_prev_out_1 <= w_y;
                    r_state      <= ST_SUM;
                end
                ST_SUM: begin
                    r_result      <= PORT_BITS'(w_sum_sat);
                    r_result_clip <= w_sum_ovf;
                    r_state       <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_sample_out <= r_result;
                        r_clipped    <= r_result_clip;
                        r_out_valid  <= 1'b1;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_clipped    = r_clipped;

`ifndef ASSERT_OFF
    // an accepted sample always leaves the idle step
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> (r_state != ST_IDLE))
        else $error("sequencer stayed idle after taking a sample");

    // tap counter never runs past the last tap
    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |-> (r_tap <= LAST_TAP))
        else $error("tap counter out of range");

    // a new result is only loaded from the hand-off step
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("output loaded outside the hand-off step");

    // a clipped result sits at one of the rails
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clipped) |->
            ((o_sample_out == PORT_BITS'(S_MAX)) || (o_sample_out == PORT_BITS'(S_MIN))))
        else $error("clipped flag set on a value off the rails");
`endif

endmodule

// ----- sim/tb_biquad_boost_cut_eq_unit.sv -----
// ----------------------------------------------------------------------------
// tb_biquad_boost_cut_eq_unit
// self-checking bench for the boost/cut equalizer: a bit-exact fixed point
// predictor tracks gain, biquad history and saturation, and every output
// transaction is compared against it while both channels idle and stall
// ----------------------------------------------------------------------------
module tb_biquad_boost_cut_eq_unit;
    import bqeq_pkg::*;

    // predictor formats at the default parameters
    localparam int SMP_W   = SAMPLE_BITS_DEF;
    localparam int FRAC    = COEF_FRAC_BITS_DEF;
    localparam int DRY_W   = SAMPLE_BITS_DEF + 2;
    localparam int HIST_W  = SAMPLE_BITS_DEF + STATE_GUARD_BITS_DEF;
    localparam int PROD_W  = 2 * COEF_BITS + 2;
    localparam int ACC_W   = 80;
    localparam int MIX_W   = HIST_W + 1;

    localparam logic signed [PROD_W-1:0] GAIN_ROUND = 66'sd1 <<< (FRAC - 1);
    localparam logic signed [ACC_W-1:0]  ACC_ROUND  = 80'sd1 <<< (FRAC - 1);

    // register index that decodes to nothing
    localparam logic [CFG_IDX_BITS-1:0] REG_NONE = 3'd7;

    localparam int RUN_LIMIT = 1_000_000;
    localparam int LONG_HOLD = 300;
    localparam int TAIL_CYCLES = 24;

    typedef struct packed {
        logic [PORT_BITS-1:0] smp;
        logic                 clip;
    } t_eq_result;

    typedef struct {
        logic signed [COEF_BITS-1:0] gain, b0, b1, b2, a1, a2;
        logic                        bypass;
    } t_eq_setting;

    typedef enum int {SET_BANDPASS, SET_WILD, SET_BYPASS, SET_DRY} t_eq_kind;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    // dut connections, all known from time zero
    logic                        clk;
    logic                        rst_n     = 1'b0;
    logic                        cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]     cfg_idx   = '0;
    logic [COEF_BITS-1:0]        cfg_data  = '0;
    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    logic signed [PORT_BITS-1:0] sample_in = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic signed [PORT_BITS-1:0] sample_out;
    logic                        clipped;

    // predictor copy of the registers and of the filter history
    logic signed [COEF_BITS-1:0] cfg_gain = DRY_GAIN_RESET;
    logic signed [COEF_BITS-1:0] cfg_b0 = '0, cfg_b1 = '0, cfg_b2 = '0;
    logic signed [COEF_BITS-1:0] cfg_a1 = '0, cfg_a2 = '0;
    logic                        cfg_bypass = 1'b0;
    logic signed [DRY_W-1:0]     hist_d1 = '0, hist_d2 = '0;
    logic signed [HIST_W-1:0]    hist_y1 = '0, hist_y2 = '0;

    t_eq_result pending_out[$];

    int  n_samples   = 0;
    int  n_bypassed  = 0;
    int  n_checked   = 0;
    int  n_clipped   = 0;
    int  n_mismatch  = 0;
    int  n_settings  = 0;
    int  cycle_count = 0;
    int  burst_left  = 0;
    bit  sender_gaps = 1'b1;
    int  hold_requests = 0;

    biquad_boost_cut_eq_unit u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_sample_in  (sample_in),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_sample_out (sample_out),
        .o_clipped    (clipped)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit, far above the slowest legal run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results still expected",
                     $time, cycle_count, pending_out.size());
            $display("tb_biquad_boost_cut_eq_unit: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // predictor: gain, df1 biquad, dry add and saturation, bit exact
    // ------------------------------------------------------------------------
    task automatic eq_predict(input logic [PORT_BITS-1:0] smp, output t_eq_result res);
        logic signed [PROD_W-1:0] scaled;
        logic signed [DRY_W-1:0]  dry;
        logic signed [ACC_W-1:0]  acc;
        logic signed [HIST_W-1:0] wet;
        logic signed [MIX_W-1:0]  mix;
        if (cfg_bypass) begin
            // pass through untouched, history frozen
            res.smp  = smp;
            res.clip = 1'b0;
        end else begin
            // round-half-up scale by the dry gain, always fits dry width
            scaled = ($signed(smp) * cfg_gain + GAIN_ROUND) >>> FRAC;
            dry    = scaled[DRY_W-1:0];

            // exact accumulation, feedback taps already negated in software
            acc = ACC_ROUND + cfg_b0 * dry + cfg_b1 * hist_d1 + cfg_b2 * hist_d2
                + cfg_a1 * hist_y1 + cfg_a2 * hist_y2;
            acc = acc >>> FRAC;

            // filter output clamps to the history range, silently
            if (acc[ACC_W-1:HIST_W-1] == '0 || acc[ACC_W-1:HIST_W-1] == '1)
                wet = acc[HIST_W-1:0];
            else
                wet = acc[ACC_W-1] ? {1'b1, {(HIST_W-1){1'b0}}}
                                   : {1'b0, {(HIST_W-1){1'b1}}};

            hist_d2 = hist_d1;
            hist_d1 = dry;
            hist_y2 = hist_y1;
            hist_y1 = wet;

            // dry plus wet, clamped to the sample range and flagged
            mix = dry + wet;
            if (mix[MIX_W-1:SMP_W-1] == '0 || mix[MIX_W-1:SMP_W-1] == '1) begin
                res.smp  = mix[SMP_W-1:0];
                res.clip = 1'b0;
            end else begin
                res.smp  = mix[MIX_W-1] ? {1'b1, {(SMP_W-1){1'b0}}}
                                        : {1'b0, {(SMP_W-1){1'b1}}};
                res.clip = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // output side: compare every output transaction with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : out_checker
        t_eq_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_out.size() == 0) begin
                n_mismatch++;
                $display("%0t: result with nothing expected: sample_out %h clipped %b",
                         $time, sample_out, clipped);
            end else begin
                want = pending_out.pop_front();
                n_checked++;
                if (want.clip)
                    n_clipped++;
                if (sample_out !== want.smp) begin
                    n_mismatch++;
                    $display("%0t: sample_out mismatch: expected %h actual %h",
                             $time, want.smp, sample_out);
                end
                if (clipped !== want.clip) begin
                    n_mismatch++;
                    $display("%0t: clipped mismatch: expected %b actual %b",
                             $time, want.clip, clipped);
                end
            end
        end
    end

    // receiver stall: random modes over random spans, plus a long counted hold
    // whenever a test asks for one
    initial begin : out_stall_pattern
        t_stall_mode mode;
        int span;
        int tick;
        int hold_left;
        int holds_served;
        span         = 0;
        tick         = 0;
        hold_left    = 0;
        holds_served = 0;
        mode = STALL_NONE;
        forever begin
            @(posedge clk);
            if (span == 0) begin
                mode = t_stall_mode'($urandom_range(0, 3));
                span = $urandom_range(32, 256);
            end
            span--;
            tick++;
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                case (mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:     out_stall <= ((tick % 7) < 3);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // shared stimulus tasks
    // ------------------------------------------------------------------------

    // one input transaction; bursts with random gaps, valid stays up within a burst
    task automatic send_sample(input logic [PORT_BITS-1:0] smp);
        t_eq_result res;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = sender_gaps ? $urandom_range(0, 10) : 0;
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        sample_in <= smp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // transaction taken at this edge
        eq_predict(smp, res);
        pending_out.push_back(res);
        n_samples++;
        if (cfg_bypass)
            n_bypassed++;
    endtask

    // stop offering and wait for every predicted result; the block is idle after
    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending_out.size() != 0);
    endtask

    task automatic program_reg(input logic [CFG_IDX_BITS-1:0] idx,
                               input logic [COEF_BITS-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_DRY_GAIN: cfg_gain   = data;
            REG_COEF_B0:  cfg_b0     = data;
            REG_COEF_B1:  cfg_b1     = data;
            REG_COEF_B2:  cfg_b2     = data;
            REG_COEF_A1:  cfg_a1     = data;
            REG_COEF_A2:  cfg_a2     = data;
            REG_BYPASS:   cfg_bypass = data[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_setting(input t_eq_setting s);
        logic [COEF_BITS-1:0] byp_word;
        // junk in the upper bits of the bypass word must be ignored
        byp_word    = $urandom();
        byp_word[0] = s.bypass;
        program_reg(REG_DRY_GAIN, s.gain);
        program_reg(REG_COEF_B0, s.b0);
        program_reg(REG_COEF_B1, s.b1);
        program_reg(REG_COEF_B2, s.b2);
        program_reg(REG_COEF_A1, s.a1);
        program_reg(REG_COEF_A2, s.a2);
        program_reg(REG_BYPASS, byp_word);
        n_settings++;
    endtask

    // mostly full-range noise, some quieter material and some rail values
    function automatic logic [PORT_BITS-1:0] rand_sample();
        logic [PORT_BITS-1:0] r;
        r = $urandom();
        case ($urandom_range(0, 9))
            0: r = 32'h7FFF_FFFF;
            1: r = 32'h8000_0000;
            2, 3, 4: r = $signed(r) >>> $urandom_range(4, 16);
            default: ;
        endcase
        return r;
    endfunction

    // band-pass by default: b2 = -b0, poles kept inside the stability triangle
    function automatic t_eq_setting pick_setting(input t_eq_kind kind);
        t_eq_setting s;
        int unsigned pole_r2;
        int unsigned a1_lim;
        pole_r2  = $urandom_range(32'h2000_0000, 32'h3EB8_51EB);
        a1_lim   = ((32'h4000_0000 + pole_r2) / 32) * 31;
        s.gain   = $urandom_range(32'h1000_0000, 32'h7FFF_FFFF);
        s.b0     = $urandom_range(0, 32'h2000_0000);
        s.b1     = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
        s.b2     = -s.b0;
        s.a1     = $urandom_range(0, 2 * a1_lim) - a1_lim;
        s.a2     = -pole_r2;
        s.bypass = 1'b0;
        case (kind)
            SET_WILD: begin
                // anything goes: heavy filter saturation and clipping
                s.gain = $urandom();
                s.b0   = $urandom();
                s.b1   = $urandom();
                s.b2   = $urandom();
                s.a1   = $urandom();
                s.a2   = $urandom();
            end
            SET_BYPASS: begin
                s.gain   = $urandom();
                s.b0     = $urandom();
                s.a1     = $urandom();
                s.bypass = 1'b1;
            end
            SET_DRY: begin
                s.gain = $urandom();
                s.b0   = '0;
                s.b1   = '0;
                s.b2   = '0;
                s.a1   = '0;
                s.a2   = '0;
            end
            default: ;
        endcase
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset values: default dry gain only, zero taps; large inputs clip
    task automatic test_reset_defaults();
        drain_results();
        send_sample(32'h0000_0000);
        send_sample(32'h0000_0001);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h4000_0000);
        send_sample(32'h73C0_0000);
        send_sample(32'hC000_0000);
    endtask

    // unity gain band-pass: impulse, ringing, then single full-scale samples of both signs
    task automatic test_impulse_response();
        t_eq_setting s;
        s.gain   = 32'sh4000_0000;
        s.b0     = 32'sd53687091;
        s.b1     = 32'sd0;
        s.b2     = -32'sd53687091;
        s.a1     = 32'sd1932735283;
        s.a2     = -32'sd966367642;
        s.bypass = 1'b0;
        drain_results();
        load_setting(s);
        send_sample(32'h4000_0000);
        repeat (4) send_sample(32'h0000_0000);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h0000_0000);
    endtask

    // bypass passes all bits and freezes history; ringing resumes afterwards
    task automatic test_bypass_holds_state();
        drain_results();
        program_reg(REG_BYPASS, {31'($urandom_range(0, 32'h7FFF_FFFF)), 1'b1});
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h1234_5678);
        send_sample(32'hFFFF_FFFF);
        drain_results();
        program_reg(REG_BYPASS, {31'($urandom_range(0, 32'h7FFF_FFFF)), 1'b0});
        repeat (3) send_sample(32'h0000_0000);
    endtask

    // a write to an undecoded index must leave every register alone
    task automatic test_bad_register_index();
        drain_results();
        program_reg(REG_NONE, $urandom());
        send_sample(32'h4000_0000);
        send_sample(32'h0000_0000);
    endtask

    // registers at their rails and at zero gain
    task automatic test_register_extremes();
        t_eq_setting s;
        for (int pass = 0; pass < 4; pass++) begin
            case (pass)
                0: begin
                    s.gain = 32'sh7FFF_FFFF; s.b0 = 32'sh7FFF_FFFF; s.b1 = 32'sh7FFF_FFFF;
                    s.b2 = 32'sh7FFF_FFFF; s.a1 = 32'sh7FFF_FFFF; s.a2 = 32'sh7FFF_FFFF;
                end
                1: begin
                    s.gain = 32'sh8000_0000; s.b0 = 32'sh8000_0000; s.b1 = 32'sh8000_0000;
                    s.b2 = 32'sh8000_0000; s.a1 = 32'sh8000_0000; s.a2 = 32'sh8000_0000;
                end
                2: begin
                    s.gain = '0; s.b0 = $urandom(); s.b1 = $urandom();
                    s.b2 = $urandom(); s.a1 = $urandom(); s.a2 = $urandom();
                end
                default: begin
                    s.gain = 32'sh8000_0000; s.b0 = 32'sh7FFF_FFFF; s.b1 = 32'sh8000_0000;
                    s.b2 = 32'sh7FFF_FFFF; s.a1 = 32'sh8000_0000; s.a2 = 32'sh7FFF_FFFF;
                end
            endcase
            s.bypass = 1'b0;
            drain_results();
            load_setting(s);
            repeat (40) send_sample(rand_sample());
        end
    endtask

    // receiver holds off for a long counted stretch while samples keep coming,
    // so the output register fills and the input side stalls
    task automatic test_output_backpressure();
        drain_results();
        load_setting(pick_setting(SET_BANDPASS));
        sender_gaps = 1'b0;
        hold_requests++;
        repeat (60) send_sample(rand_sample());
        sender_gaps = 1'b1;
    endtask

    // random settings of every kind, well-behaved band-pass filters chosen most often
    task automatic test_random_settings();
        t_eq_kind kind;
        for (int ph = 0; ph < 14; ph++) begin
            if (ph < 4)
                kind = t_eq_kind'(ph);
            else if ($urandom_range(0, 5) < 3)
                kind = SET_BANDPASS;
            else
                kind = t_eq_kind'($urandom_range(1, 3));
            drain_results();
            load_setting(pick_setting(kind));
            // some phases run with no sender gaps at all
            sender_gaps = ($urandom_range(0, 3) != 0);
            repeat (120) send_sample(rand_sample());
        end
        sender_gaps = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_impulse_response();
        test_bypass_holds_state();
        test_bad_register_index();
        test_register_extremes();
        test_output_backpressure();
        test_random_settings();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d samples (%0d bypassed), %0d results checked, %0d clipped",
                 n_samples, n_bypassed, n_checked, n_clipped);
        $display("over %0d register settings incl. rails, bad index, long output hold",
                 n_settings);
        if (n_mismatch == 0 && pending_out.size() == 0) begin
            $display("tb_biquad_boost_cut_eq_unit: clean");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     n_mismatch, pending_out.size());
            $display("tb_biquad_boost_cut_eq_unit: errors");
        end
        $finish;
    end

endmodule
